// ===== rtl/qcis_pkg.sv =====
// shared types and constants for the quad cell isoline segment block
// no dependencies
`default_nettype none

package qcis_pkg;

  localparam int VAL_W      = 32;          // width of values and coordinates
  localparam int ROOT_W     = 32;          // width of the square root result
  localparam int SQ_W       = 2 * ROOT_W;  // width of the radicand
  localparam int NORM_SHIFT = 30;          // fraction bits of the unit normal

  typedef logic [1:0] corner_t;
  typedef logic signed [VAL_W:0] diff_t;

endpackage

`default_nettype wire

// ===== rtl/qcis_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
// computes floor(num * 2^(QW-1) / den) for num <= den; no package use
`default_nettype none

module qcis_div #(
  parameter int DW = 34,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW-1:0] dsrc;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign trial = {1'b0, num};
      assign dsrc  = den;
    end else begin : g_next
      assign trial = {rem_q[k-1], 1'b0};
      assign dsrc  = den_q[k-1];
    end

    assign ge   = (trial >= {1'b0, dsrc});
    assign diff = trial - {1'b0, dsrc};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_q[k] <= dsrc;
        if (k == 0) begin
          quo_q[k]  <= {{(QW-1){1'b0}}, ge};
          side_q[k] <= side_in;
        end else begin
          quo_q[k]  <= {quo_q[(k == 0) ? 0 : k-1][QW-2:0], ge};
          side_q[k] <= side_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = quo_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule

`default_nettype wire

// ===== rtl/qcis_isqrt.sv =====
// pipelined integer square root, one result bit per stage, with sideband
// depends on qcis_pkg for radicand and root widths
`default_nettype none

module qcis_isqrt
  import qcis_pkg::*;
#(
  parameter int SW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   radicand,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SW-1:0]     side_out
);

  logic [SQ_W-1:0]   n_q    [ROOT_W];
  logic [SQ_W-1:0]   r_q    [ROOT_W];
  logic [SW-1:0]     side_q [ROOT_W];
  logic [ROOT_W-1:0] vld;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2*k);
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] t;
    logic            ge;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign t  = r_in + BIT;
    assign ge = (n_in >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]    <= ge ? (n_in - t) : n_in;
        r_q[k]    <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
        side_q[k] <= (k == 0) ? side_in : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = r_q[ROOT_W-1][ROOT_W-1:0];
  assign side_out  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/quad_cell_isoline_segment.sv =====
// throughput: one item per cycle; all stages, four dividers and the root unit are pipelined
// a stalled result holds the whole pipeline, so cell_stall follows seg_valid && seg_stall
// reset (rst, synchronous) clears all valid bits and sets iso_level to 0
// depends on qcis_pkg, qcis_div and qcis_isqrt
`default_nettype none

module quad_cell_isoline_segment
  import qcis_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  // cell item
  input  logic               cell_valid,
  output logic               cell_stall,
  input  logic signed [31:0] corner0_value,
  input  logic signed [31:0] corner1_value,
  input  logic signed [31:0] corner2_value,
  input  logic signed [31:0] corner3_value,
  input  logic signed [31:0] corner0_x,
  input  logic signed [31:0] corner1_x,
  input  logic signed [31:0] corner2_x,
  input  logic signed [31:0] corner3_x,
  input  logic signed [31:0] corner0_y,
  input  logic signed [31:0] corner1_y,
  input  logic signed [31:0] corner2_y,
  input  logic signed [31:0] corner3_y,
  // segment item
  output logic               seg_valid,
  input  logic               seg_stall,
  output logic               has_segment,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  output logic signed [31:0] mid_x,
  output logic signed [31:0] mid_y,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y
);

  localparam int FW      = FRAC_BITS + 1;       // interpolation fraction, [0, 1]
  localparam int PW      = FW + 1 + VAL_W + 1;  // fraction times coordinate delta
  localparam int MW      = VAL_W + 1;           // segment delta magnitude
  localparam int NW      = NORM_SHIFT + 1;      // normalized magnitude
  localparam int CW      = 6 * VAL_W;           // bundle of six coordinates
  localparam int SIDE1_W = 2 + 2 * MW + 2 * VAL_W;
  localparam int SIDE2_W = 1 + 2 * MW + 2 * VAL_W;
  localparam int SQS_W   = 4 + 2 * NW + CW;
  localparam int ND1_W   = 3 + CW;

  // one pipeline-wide advance; everything holds while a result is stalled
  logic en;
  assign en         = !(seg_valid && seg_stall);
  assign cell_stall = seg_valid && seg_stall;

  // level register
  logic signed [31:0] iso_level;
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
    end else if (cfg_write) begin
      iso_level <= cfg_data;
    end
  end

  function automatic diff_t sel4(corner_t s, diff_t v0, diff_t v1, diff_t v2, diff_t v3);
    diff_t r;
    case (s)
      2'd0:    r = v0;
      2'd1:    r = v1;
      2'd2:    r = v2;
      default: r = v3;
    endcase
    return r;
  endfunction

  function automatic logic [MW:0] mag34(diff_t v);
    logic [MW:0] e;
    e = {v[VAL_W], v};
    return v[VAL_W] ? (~e + 1'b1) : e;
  endfunction

  // ---------------------------------------------------------------------------
  // stage 1: corner values minus level, exact 33-bit differences
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  diff_t              s1_g  [4];
  logic signed [31:0] s1_px [4];
  logic signed [31:0] s1_py [4];
  logic signed [31:0] cv [4];
  logic signed [31:0] cx [4];
  logic signed [31:0] cy [4];

  assign cv = '{corner0_value, corner1_value, corner2_value, corner3_value};
  assign cx = '{corner0_x, corner1_x, corner2_x, corner3_x};
  assign cy = '{corner0_y, corner1_y, corner2_y, corner3_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_g[i]  <= {cv[i][31], cv[i]} - {iso_level[31], iso_level};
        s1_px[i] <= cx[i];
        s1_py[i] <= cy[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: classify corners, pick the two crossed edges
  // ---------------------------------------------------------------------------
  logic               s2_valid, s2_seg;
  corner_t            s2_a1, s2_b1, s2_a2, s2_b2;
  diff_t              s2_g  [4];
  logic signed [31:0] s2_px [4];
  logic signed [31:0] s2_py [4];

  logic [3:0] low, neg, pos;
  logic [2:0] low_cnt, high_cnt;
  logic       seg_next;
  corner_t    a1_next, b1_next, a2_next, b2_next;

  always_comb begin
    low_cnt  = '0;
    high_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i]   = s1_g[i][VAL_W];
      pos[i]   = !s1_g[i][VAL_W] && (s1_g[i] != '0);
      low[i]   = !pos[i];
      low_cnt  = low_cnt + {2'b00, low[i]};
      high_cnt = high_cnt + {2'b00, !neg[i]};
    end
    seg_next = 1'b0;
    a1_next  = '0;
    b1_next  = '0;
    a2_next  = '0;
    b2_next  = '0;
    if (low_cnt == 3'd1 || high_cnt == 3'd1) begin
      // lone odd corner: edges to both neighbors
      for (int i = 0; i < 4; i++) begin
        if ((low_cnt == 3'd1 && neg[i]) || (high_cnt == 3'd1 && pos[i])) begin
          seg_next = 1'b1;
          a1_next  = corner_t'(i);
          b1_next  = corner_t'(i + 1);
          a2_next  = corner_t'(i);
          b2_next  = corner_t'(i + 3);
        end
      end
    end else if (low_cnt == 3'd2) begin
      // adjacent pair only; a diagonal pair is a saddle
      if (low[0] != low[2]) begin
        seg_next = 1'b1;
        if (low[0] != low[1]) begin
          a1_next = 2'd0; b1_next = 2'd1; a2_next = 2'd2; b2_next = 2'd3;
        end else begin
          a1_next = 2'd1; b1_next = 2'd2; a2_next = 2'd3; b2_next = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_seg <= seg_next;
      s2_a1  <= a1_next;
      s2_b1  <= b1_next;
      s2_a2  <= a2_next;
      s2_b2  <= b2_next;
      s2_g   <= s1_g;
      s2_px  <= s1_px;
      s2_py  <= s1_py;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: edge operands: |g_a|, |g_a| + |g_b|, coordinate deltas
  // ---------------------------------------------------------------------------
  logic               s3_valid, s3_seg;
  logic [MW:0]        s3_num1, s3_den1, s3_num2, s3_den2;
  diff_t              s3_dx1, s3_dy1, s3_dx2, s3_dy2;
  logic signed [31:0] s3_pax1, s3_pay1, s3_pax2, s3_pay2;

  diff_t ex0, ex1, ex2, ex3, ey0, ey1, ey2, ey3;
  diff_t ga1, gb1, ga2, gb2, xa1, xb1, ya1, yb1, xa2, xb2, ya2, yb2;
  logic [MW:0] na1, na2;

  always_comb begin
    ex0 = {s2_px[0][31], s2_px[0]};
    ex1 = {s2_px[1][31], s2_px[1]};
    ex2 = {s2_px[2][31], s2_px[2]};
    ex3 = {s2_px[3][31], s2_px[3]};
    ey0 = {s2_py[0][31], s2_py[0]};
    ey1 = {s2_py[1][31], s2_py[1]};
    ey2 = {s2_py[2][31], s2_py[2]};
    ey3 = {s2_py[3][31], s2_py[3]};
    ga1 = sel4(s2_a1, s2_g[0], s2_g[1], s2_g[2], s2_g[3]);
    gb1 = sel4(s2_b1, s2_g[0], s2_g[1], s2_g[2], s2_g[3]);
    ga2 = sel4(s2_a2, s2_g[0], s2_g[1], s2_g[2], s2_g[3]);
    gb2 = sel4(s2_b2, s2_g[0], s2_g[1], s2_g[2], s2_g[3]);
    xa1 = sel4(s2_a1, ex0, ex1, ex2, ex3);
    xb1 = sel4(s2_b1, ex0, ex1, ex2, ex3);
    ya1 = sel4(s2_a1, ey0, ey1, ey2, ey3);
    yb1 = sel4(s2_b1, ey0, ey1, ey2, ey3);
    xa2 = sel4(s2_a2, ex0, ex1, ex2, ex3);
    xb2 = sel4(s2_b2, ex0, ex1, ex2, ex3);
    ya2 = sel4(s2_a2, ey0, ey1, ey2, ey3);
    yb2 = sel4(s2_b2, ey0, ey1, ey2, ey3);
    na1 = mag34(ga1);
    na2 = mag34(ga2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_seg  <= s2_seg;
      s3_num1 <= na1;
      s3_den1 <= na1 + mag34(gb1);
      s3_num2 <= na2;
      s3_den2 <= na2 + mag34(gb2);
      s3_dx1  <= xb1 - xa1;
      s3_dy1  <= yb1 - ya1;
      s3_dx2  <= xb2 - xa2;
      s3_dy2  <= yb2 - ya2;
      s3_pax1 <= xa1[31:0];
      s3_pay1 <= ya1[31:0];
      s3_pax2 <= xa2[31:0];
      s3_pay2 <= ya2[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // interpolation fractions: two dividers side by side, FW stages each
  // ---------------------------------------------------------------------------
  logic               d1_valid, d2_valid;
  logic [FW-1:0]      d1_quo, d2_quo;
  logic [SIDE1_W-1:0] d1_side;
  logic [SIDE2_W-1:0] d2_side;

  qcis_div #(.DW(MW + 1), .QW(FW), .SW(SIDE1_W)) u_frac_start (
    .clk(clk), .rst(rst), .en(en), .in_valid(s3_valid),
    .num(s3_num1), .den(s3_den1),
    .side_in({s3_seg, (s3_den1 == '0), s3_dx1, s3_dy1, s3_pax1, s3_pay1}),
    .out_valid(d1_valid), .quo(d1_quo), .side_out(d1_side)
  );

  qcis_div #(.DW(MW + 1), .QW(FW), .SW(SIDE2_W)) u_frac_end (
    .clk(clk), .rst(rst), .en(en), .in_valid(s3_valid),
    .num(s3_num2), .den(s3_den2),
    .side_in({(s3_den2 == '0), s3_dx2, s3_dy2, s3_pax2, s3_pay2}),
    .out_valid(d2_valid), .quo(d2_quo), .side_out(d2_side)
  );

  logic               d_seg, d_zero1, d_zero2;
  diff_t              d_dx1, d_dy1, d_dx2, d_dy2;
  logic signed [31:0] d_pax1, d_pay1, d_pax2, d_pay2;
  logic signed [FW:0] fr1, fr2;

  assign {d_seg, d_zero1, d_dx1, d_dy1, d_pax1, d_pay1} = d1_side;
  assign {d_zero2, d_dx2, d_dy2, d_pax2, d_pay2}        = d2_side;
  // a zero denominator means both corners sit on the level: fraction 0
  assign fr1 = d_zero1 ? '0 : {1'b0, d1_quo};
  assign fr2 = d_zero2 ? '0 : {1'b0, d2_quo};

  // ---------------------------------------------------------------------------
  // stage 4: fraction times delta
  // ---------------------------------------------------------------------------
  logic                 s4_valid, s4_seg;
  logic signed [PW-1:0] s4_px1, s4_py1, s4_px2, s4_py2;
  logic signed [31:0]   s4_pax1, s4_pay1, s4_pax2, s4_pay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_seg  <= d_seg;
      s4_px1  <= fr1 * d_dx1;
      s4_py1  <= fr1 * d_dy1;
      s4_px2  <= fr2 * d_dx2;
      s4_py2  <= fr2 * d_dy2;
      s4_pax1 <= d_pax1;
      s4_pay1 <= d_pay1;
      s4_pax2 <= d_pax2;
      s4_pay2 <= d_pay2;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: endpoints, base plus floored scaled product
  // ---------------------------------------------------------------------------
  logic                 s5_valid, s5_seg;
  logic signed [31:0]   s5_sx, s5_sy, s5_ex, s5_ey;
  logic signed [PW-1:0] t_sx, t_sy, t_ex, t_ey;

  always_comb begin
    t_sx = (s4_px1 >>> FRAC_BITS) + PW'(s4_pax1);
    t_sy = (s4_py1 >>> FRAC_BITS) + PW'(s4_pay1);
    t_ex = (s4_px2 >>> FRAC_BITS) + PW'(s4_pax2);
    t_ey = (s4_py2 >>> FRAC_BITS) + PW'(s4_pay2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_seg <= s4_seg;
      s5_sx  <= t_sx[31:0];
      s5_sy  <= t_sy[31:0];
      s5_ex  <= t_ex[31:0];
      s5_ey  <= t_ey[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: midpoint, normal direction and its magnitudes
  // ---------------------------------------------------------------------------
  logic               s6_valid, s6_seg, s6_negx, s6_negy;
  logic signed [31:0] s6_sx, s6_sy, s6_ex, s6_ey, s6_mx, s6_my;
  logic [MW-1:0]      s6_ma, s6_mb, s6_m;

  diff_t       sum_x, sum_y, nx, ny;
  logic [MW:0] ma_w, mb_w;

  always_comb begin
    sum_x = {s5_sx[31], s5_sx} + {s5_ex[31], s5_ex};
    sum_y = {s5_sy[31], s5_sy} + {s5_ey[31], s5_ey};
    nx    = {s5_ey[31], s5_ey} - {s5_sy[31], s5_sy};
    ny    = {s5_sx[31], s5_sx} - {s5_ex[31], s5_ex};
    ma_w  = mag34(nx);
    mb_w  = mag34(ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_seg  <= s5_seg;
      s6_sx   <= s5_sx;
      s6_sy   <= s5_sy;
      s6_ex   <= s5_ex;
      s6_ey   <= s5_ey;
      s6_mx   <= sum_x[32:1];
      s6_my   <= sum_y[32:1];
      s6_negx <= nx[VAL_W];
      s6_negy <= ny[VAL_W];
      s6_ma   <= ma_w[MW-1:0];
      s6_mb   <= mb_w[MW-1:0];
      s6_m    <= (ma_w > mb_w) ? ma_w[MW-1:0] : mb_w[MW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: leading one of the larger magnitude
  // ---------------------------------------------------------------------------
  logic               s7_valid, s7_seg, s7_negx, s7_negy, s7_zero;
  logic [CW-1:0]      s7_coords;
  logic [MW-1:0]      s7_ma, s7_mb;
  logic [5:0]         s7_pos;
  logic [5:0]         lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MW; i++) begin
      if (s6_m[i]) begin
        lead = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_seg    <= s6_seg;
      s7_negx   <= s6_negx;
      s7_negy   <= s6_negy;
      s7_zero   <= (s6_m == '0);
      s7_coords <= {s6_sx, s6_sy, s6_ex, s6_ey, s6_mx, s6_my};
      s7_ma     <= s6_ma;
      s7_mb     <= s6_mb;
      s7_pos    <= lead;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: normalize so the larger magnitude lands in [2^30, 2^31)
  // ---------------------------------------------------------------------------
  localparam logic [5:0] TOP_POS = 6'(NORM_SHIFT);

  logic               s8_valid, s8_seg, s8_negx, s8_negy, s8_zero;
  logic [CW-1:0]      s8_coords;
  logic [NW-1:0]      s8_ma, s8_mb;
  logic [NW-1:0]      na_n, nb_n;

  always_comb begin
    if (s7_pos > TOP_POS) begin
      // right shift drops low bits, same as the truncating halving
      na_n = NW'(s7_ma >> (s7_pos - TOP_POS));
      nb_n = NW'(s7_mb >> (s7_pos - TOP_POS));
    end else begin
      na_n = NW'({{NW{1'b0}}, s7_ma} << (TOP_POS - s7_pos));
      nb_n = NW'({{NW{1'b0}}, s7_mb} << (TOP_POS - s7_pos));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_seg    <= s7_seg;
      s8_negx   <= s7_negx;
      s8_negy   <= s7_negy;
      s8_zero   <= s7_zero;
      s8_coords <= s7_coords;
      s8_ma     <= na_n;
      s8_mb     <= nb_n;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: squares; stage 10: sum of squares
  // ---------------------------------------------------------------------------
  logic               s9_valid, s9_seg, s9_negx, s9_negy, s9_zero;
  logic [CW-1:0]      s9_coords;
  logic [NW-1:0]      s9_ma, s9_mb;
  logic [2*NW-1:0]    s9_sqa, s9_sqb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_seg    <= s8_seg;
      s9_negx   <= s8_negx;
      s9_negy   <= s8_negy;
      s9_zero   <= s8_zero;
      s9_coords <= s8_coords;
      s9_ma     <= s8_ma;
      s9_mb     <= s8_mb;
      s9_sqa    <= s8_ma * s8_ma;
      s9_sqb    <= s8_mb * s8_mb;
    end
  end

  logic               s10_valid;
  logic [SQS_W-1:0]   s10_side;
  logic [SQ_W-1:0]    s10_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_sum  <= SQ_W'(s9_sqa) + SQ_W'(s9_sqb);
      s10_side <= {s9_seg, s9_zero, s9_negx, s9_negy, s9_ma, s9_mb, s9_coords};
    end
  end

  // ---------------------------------------------------------------------------
  // segment length: pipelined root, ROOT_W stages
  // ---------------------------------------------------------------------------
  logic              q_valid;
  logic [ROOT_W-1:0] q_root;
  logic [SQS_W-1:0]  q_side;

  qcis_isqrt #(.SW(SQS_W)) u_len (
    .clk(clk), .rst(rst), .en(en), .in_valid(s10_valid),
    .radicand(s10_sum), .side_in(s10_side),
    .out_valid(q_valid), .root(q_root), .side_out(q_side)
  );

  logic          q_seg, q_zero, q_negx, q_negy;
  logic [NW-1:0] q_ma, q_mb;
  logic [CW-1:0] q_coords;

  assign {q_seg, q_zero, q_negx, q_negy, q_ma, q_mb, q_coords} = q_side;

  // ---------------------------------------------------------------------------
  // unit normal: two dividers, NW stages each
  // ---------------------------------------------------------------------------
  logic             n1_valid, n2_valid;
  logic [NW-1:0]    n1_quo, n2_quo;
  logic [ND1_W-1:0] n1_side;
  logic             n2_side;

  qcis_div #(.DW(ROOT_W), .QW(NW), .SW(ND1_W)) u_norm_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid),
    .num({{(ROOT_W-NW){1'b0}}, q_ma}), .den(q_root),
    .side_in({q_seg, q_zero, q_negx, q_coords}),
    .out_valid(n1_valid), .quo(n1_quo), .side_out(n1_side)
  );

  qcis_div #(.DW(ROOT_W), .QW(NW), .SW(1)) u_norm_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid),
    .num({{(ROOT_W-NW){1'b0}}, q_mb}), .den(q_root),
    .side_in(q_negy),
    .out_valid(n2_valid), .quo(n2_quo), .side_out(n2_side)
  );

  logic               o_seg, o_zero, o_negx;
  logic [CW-1:0]      o_coords;
  logic signed [31:0] o_sx, o_sy, o_ex, o_ey, o_mx, o_my;
  logic [31:0]        o_nx, o_ny;

  assign {o_seg, o_zero, o_negx, o_coords} = n1_side;
  assign {o_sx, o_sy, o_ex, o_ey, o_mx, o_my} = o_coords;

  always_comb begin
    o_nx = {{(32-NW){1'b0}}, n1_quo};
    o_ny = {{(32-NW){1'b0}}, n2_quo};
    if (o_negx) begin
      o_nx = ~o_nx + 32'd1;
    end
    if (n2_side) begin
      o_ny = ~o_ny + 32'd1;
    end
    // zero-length segment has no direction
    if (o_zero) begin
      o_nx = '0;
      o_ny = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // output register; no-segment items come out all zero
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (en) begin
      seg_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      has_segment <= o_seg;
      start_x     <= o_seg ? o_sx : '0;
      start_y     <= o_seg ? o_sy : '0;
      end_x       <= o_seg ? o_ex : '0;
      end_y       <= o_seg ? o_ey : '0;
      mid_x       <= o_seg ? o_mx : '0;
      mid_y       <= o_seg ? o_my : '0;
      normal_x    <= o_seg ? o_nx : '0;
      normal_y    <= o_seg ? o_ny : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_reset_clears: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("result valid right after reset");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (d1_valid == d2_valid) && (n1_valid == n2_valid))
    else $error("paired dividers out of step");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !has_segment |->
      start_x == 0 && end_y == 0 && mid_x == 0 && normal_x == 0 && normal_y == 0)
    else $error("item without segment carries data");

  a_normal_set: assert property (@(posedge clk) disable iff (rst)
    seg_valid && has_segment && (start_x != end_x || start_y != end_y) |->
      (normal_x != 0 || normal_y != 0))
    else $error("segment of nonzero length with zero normal");

endmodule

`default_nettype wire

// ===== tb/sv/quad_cell_isoline_segment_tb.sv =====
// testbench for quad_cell_isoline_segment: directed and random cells, stalls, level changes
// depends on qcis_pkg and the quad_cell_isoline_segment rtl
`default_nettype none

module quad_cell_isoline_segment_tb
  import qcis_pkg::*;
;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 75;
  localparam int IDLE_LIMIT = 4000;

  // one cell item and one segment item
  typedef struct {
    logic signed [31:0] val[4];
    logic signed [31:0] px[4];
    logic signed [31:0] py[4];
  } cell_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] sx, sy, ex, ey, mx, my, nx, ny;
  } seg_t;

  // holds expected segments in order and compares each arriving one
  class seg_scoreboard;
    seg_t pending[$];
    int   errors = 0;
    int   checked = 0;
    int   segments = 0;

    function void note(seg_t e);
      pending = {pending, e};
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check(seg_t a);
      seg_t e;
      if (pending.size() == 0) begin
        $error("segment item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.hit) segments++;
      cmp("has_segment", e.hit, a.hit);
      cmp("start_x", e.sx, a.sx);
      cmp("start_y", e.sy, a.sy);
      cmp("end_x", e.ex, a.ex);
      cmp("end_y", e.ey, a.ey);
      cmp("mid_x", e.mx, a.mx);
      cmp("mid_y", e.my, a.my);
      cmp("normal_x", e.nx, a.nx);
      cmp("normal_y", e.ny, a.ny);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [31:0] cfg_data = '0;
  logic cell_valid = 0;
  logic cell_stall;
  logic signed [31:0] c0v = 0, c1v = 0, c2v = 0, c3v = 0;
  logic signed [31:0] c0x = 0, c1x = 0, c2x = 0, c3x = 0;
  logic signed [31:0] c0y = 0, c1y = 0, c2y = 0, c3y = 0;
  logic seg_valid;
  logic seg_stall = 0;
  logic has_segment;
  logic signed [31:0] start_x, start_y, end_x, end_y, mid_x, mid_y, normal_x, normal_y;

  seg_scoreboard sb = new();
  longint level = 0;        // our copy of iso_level
  bit     quiet = 0;        // when set, neither side idles
  int     idle_cycles = 0;

  quad_cell_isoline_segment #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .cell_valid(cell_valid), .cell_stall(cell_stall),
    .corner0_value(c0v), .corner1_value(c1v), .corner2_value(c2v), .corner3_value(c3v),
    .corner0_x(c0x), .corner1_x(c1x), .corner2_x(c2x), .corner3_x(c3x),
    .corner0_y(c0y), .corner1_y(c1y), .corner2_y(c2y), .corner3_y(c3y),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .has_segment(has_segment),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .mid_x(mid_x), .mid_y(mid_y), .normal_x(normal_x), .normal_y(normal_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // point on edge a->b where the offset field crosses zero, for one coordinate
  function automatic longint edge_coord(longint ga, longint gb, longint pa, longint pb);
    longint unsigned num = magnitude(ga);
    longint unsigned den = num + magnitude(gb);
    longint fr = 0;
    if (den != 0) fr = longint'((num << FRAC) / den);
    // arithmetic shift of a signed value is the floor division
    return pa + ((fr * (pb - pa)) >>> FRAC);
  endfunction

  function automatic seg_t predict_segment(cell_t c);
    longint g[4], px[4], py[4];
    int nlow = 0, nhigh = 0;
    int a1 = 0, b1 = 0, a2 = 0, b2 = 0;
    bit found = 0;
    bit l0, l1, l2;
    longint sx, sy, ex, ey, dx, dy;
    longint unsigned ma, mb, m, len, q;
    seg_t r;
    r = '{hit: 0, sx: 0, sy: 0, ex: 0, ey: 0, mx: 0, my: 0, nx: 0, ny: 0};
    for (int i = 0; i < 4; i++) begin
      g[i] = longint'(c.val[i]) - level;
      px[i] = c.px[i];
      py[i] = c.py[i];
      if (g[i] <= 0) nlow++;
      if (g[i] >= 0) nhigh++;
    end
    if (nlow == 1 || nhigh == 1) begin
      // odd corner must be strictly off the level
      for (int i = 0; i < 4; i++) begin
        if ((nlow == 1 && g[i] < 0) || (nhigh == 1 && g[i] > 0)) begin
          found = 1;
          a1 = i; b1 = (i + 1) % 4;
          a2 = i; b2 = (i + 3) % 4;
        end
      end
    end else if (nlow == 2) begin
      l0 = g[0] <= 0; l1 = g[1] <= 0; l2 = g[2] <= 0;
      // diagonal pairs (saddles) fall through with no segment
      if (l0 != l2) begin
        found = 1;
        if (l0 != l1) begin
          a1 = 0; b1 = 1; a2 = 2; b2 = 3;
        end else begin
          a1 = 1; b1 = 2; a2 = 3; b2 = 0;
        end
      end
    end
    if (!found) return r;
    sx = edge_coord(g[a1], g[b1], px[a1], px[b1]);
    sy = edge_coord(g[a1], g[b1], py[a1], py[b1]);
    ex = edge_coord(g[a2], g[b2], px[a2], px[b2]);
    ey = edge_coord(g[a2], g[b2], py[a2], py[b2]);
    r.hit = 1;
    r.sx = sx[31:0]; r.sy = sy[31:0]; r.ex = ex[31:0]; r.ey = ey[31:0];
    r.mx = 32'((sx + ex) >>> 1);
    r.my = 32'((sy + ey) >>> 1);
    dx = ey - sy;
    dy = sx - ex;
    ma = magnitude(dx);
    mb = magnitude(dy);
    m = ma > mb ? ma : mb;
    if (m != 0) begin
      // normalize so the larger magnitude sits in [2^30, 2^31)
      while (m >= (64'd1 << 31)) begin
        ma >>= 1; mb >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        ma <<= 1; mb <<= 1; m <<= 1;
      end
      len = int_sqrt(ma * ma + mb * mb);
      q = (ma << NORM_SHIFT) / len;
      r.nx = dx < 0 ? 32'(-longint'(q)) : 32'(q);
      q = (mb << NORM_SHIFT) / len;
      r.ny = dy < 0 ? 32'(-longint'(q)) : 32'(q);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_cell(cell_t c);
    int gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      cell_valid <= 0;
      @(posedge clk);
    end
    cell_valid <= 1;
    {c0v, c1v, c2v, c3v} <= {c.val[0], c.val[1], c.val[2], c.val[3]};
    {c0x, c1x, c2x, c3x} <= {c.px[0], c.px[1], c.px[2], c.px[3]};
    {c0y, c1y, c2y, c3y} <= {c.py[0], c.py[1], c.py[2], c.py[3]};
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    // accepted at this edge
    sb.note(predict_segment(c));
  endtask

  // let the pipeline empty out before the level changes
  task automatic drain();
    cell_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_level(logic [31:0] v);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    level = longint'(signed'(v));
    @(posedge clk);
  endtask

  // cell with a chosen sign pattern around the level; deltas small or wide
  function automatic cell_t make_cell(logic [31:0] lvl, int mode);
    cell_t c;
    longint v, d, bx, by, w, h;
    bx = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 20);
    by = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 20);
    w = $urandom_range(0, 1 << $urandom_range(0, 24));
    h = $urandom_range(0, 1 << $urandom_range(0, 24));
    for (int i = 0; i < 4; i++) begin
      if (mode == 0) begin
        c.val[i] = $urandom;
      end else begin
        d = $urandom_range(0, (1 << $urandom_range(0, 20)));
        case ($urandom_range(0, 9)) inside
          0:       v = longint'(signed'(lvl));
          [1:4]:   v = longint'(signed'(lvl)) - d;
          default: v = longint'(signed'(lvl)) + d;
        endcase
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        if (v < -64'sh80000000) v = -64'sh80000000;
        c.val[i] = v[31:0];
      end
    end
    if (mode <= 1) begin
      for (int i = 0; i < 4; i++) begin
        c.px[i] = $urandom;
        c.py[i] = $urandom;
      end
    end else begin
      // well-formed square-ish cell, corners around the boundary
      c.px[0] = 32'(bx); c.px[1] = 32'(bx + w); c.px[2] = 32'(bx + w); c.px[3] = 32'(bx);
      c.py[0] = 32'(by); c.py[1] = 32'(by); c.py[2] = 32'(by + h); c.py[3] = 32'(by + h);
    end
    return c;
  endfunction

  function automatic cell_t pattern_cell(int g0, int g1, int g2, int g3);
    cell_t c;
    c.val[0] = g0 <<< 16; c.val[1] = g1 <<< 16; c.val[2] = g2 <<< 16; c.val[3] = g3 <<< 16;
    c.px = '{0, 32'sh10000, 32'sh10000, 0};
    c.py = '{0, 0, 32'sh10000, 32'sh10000};
    return c;
  endfunction

  // ---------------------------------------------------------------- result side

  // result receiver: random stall runs per item, none while quiet
  int stall_left = 0;
  always @(posedge clk) begin
    if (seg_valid && !seg_stall) begin
      sb.check('{hit: has_segment, sx: start_x, sy: start_y, ex: end_x, ey: end_y,
                 mx: mid_x, my: mid_y, nx: normal_x, ny: normal_y});
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end
    if (stall_left > 0) begin
      seg_stall <= 1;
      stall_left--;
    end else begin
      seg_stall <= 0;
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((cell_valid && !cell_stall) || (seg_valid && !seg_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("quad_cell_isoline_segment verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    cell_t c;
    logic [31:0] levels[5];
    levels = '{32'h0, 32'h7fffffff, 32'h80000000, $urandom, 32'h00018000};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: level at reset value 0
    c.val = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    c.px = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    c.py = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    send_cell(c);                              // uniform high
    c.val = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    send_cell(c);                              // uniform low
    c.val = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    send_cell(c);                              // single low corner at extremes, huge span
    send_cell(pattern_cell(-1, 2, 3, 4));      // single low corner 0
    send_cell(pattern_cell(2, -1, 3, 4));      // single low corner 1
    send_cell(pattern_cell(2, 3, -5, 4));      // single low corner 2
    send_cell(pattern_cell(2, 3, 4, -7));      // single low corner 3
    send_cell(pattern_cell(1, -2, -3, -4));    // single high corner 0
    send_cell(pattern_cell(-2, -3, 5, -4));    // single high corner 2
    send_cell(pattern_cell(0, 2, 3, 4));       // lone odd corner on the level
    send_cell(pattern_cell(0, -2, -3, -4));    // lone odd corner on the level, other sign
    send_cell(pattern_cell(-1, -2, 3, 4));     // adjacent pair 0,1
    send_cell(pattern_cell(1, -2, -3, 4));     // adjacent pair 1,2
    send_cell(pattern_cell(1, 2, -3, -4));     // adjacent pair 2,3
    send_cell(pattern_cell(-1, 2, 3, -4));     // adjacent pair 3,0
    send_cell(pattern_cell(-1, 2, -3, 4));     // saddle on one diagonal
    send_cell(pattern_cell(1, -2, 3, -4));     // saddle on the other diagonal
    send_cell(pattern_cell(0, 0, 3, 4));       // two corners on the level
    send_cell(pattern_cell(0, 0, 0, 0));       // all on the level
    c = pattern_cell(-1, 2, 3, 4);
    c.px = '{5, 5, 5, 5};
    c.py = '{-9, -9, -9, -9};
    send_cell(c);                              // zero-length segment, zero normal
    c = pattern_cell(-1, -1, 3, 4);
    c.px = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
    c.py = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
    send_cell(c);                              // full coordinate span

    for (int p = 0; p < 5; p++) begin
      drain();
      write_level(levels[p]);
      quiet = (p == 2);
      for (int n = 0; n < 230; n++) begin
        send_cell(make_cell(levels[p], $urandom_range(0, 9)));
        // sender holds off until the pipeline has fully emptied
        if (p == 1 && n == 100) begin
          cell_valid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      quiet = 0;
    end

    cell_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("checked %0d cell items, %0d of them with a segment", sb.checked, sb.segments);
    $display("levels: zero, both extremes, random, one-and-a-half; with and without stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("quad_cell_isoline_segment verification clean");
    end else begin
      $display("quad_cell_isoline_segment verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/qcis_pkg.sv
rtl/qcis_div.sv
rtl/qcis_isqrt.sv
rtl/quad_cell_isoline_segment.sv
tb/sv/quad_cell_isoline_segment_tb.sv
